FILE: rtl/b64enc_pkg.sv
package b64enc_pkg;

  localparam int SymW     = 6;
  localparam int CharW    = 7;
  localparam int MaxChars = 4;
  localparam int FifoDepth = 2;
  localparam int PtrW     = $clog2(FifoDepth);
  localparam int CntW     = $clog2(FifoDepth + 1);

  localparam logic [CharW-1:0] PAD_CHAR = 7'h3D;

  // Characters produced by one input item, emitted from index 0 upward.
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [1:0]                     last_idx;  // number of chars minus one
    logic                           last;      // item closes the message
  } b64_entry_t;

  function automatic logic [CharW-1:0] sym_char(input logic [SymW-1:0] sym);
    logic [CharW-1:0] s;
    logic [CharW-1:0] c;
    s = {1'b0, sym};
    if (sym < 6'd26) begin
      c = 7'h41 + s;
    end else if (sym < 6'd52) begin
      c = 7'h61 + s - 7'd26;
    end else if (sym < 6'd62) begin
      c = 7'h30 + s - 7'd52;
    end else if (sym == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

FILE: rtl/base64_stream_encoder.sv
// Base64 encoder (standard alphabet, '=' padded), one message byte per item.
// Input channel: in_tdata[7:0] is the byte, in_tlast marks the last byte of
// a message. Output channel: one ASCII character per item in out_tdata[6:0],
// out_tlast on the final character of the encoded message.
// The front stage turns each byte into one to four characters and writes them
// as one entry into a two-entry queue; the back stage sends the characters of
// the head entry one per cycle while out_tready allows, through a registered output.
// With the queue empty, a byte that is taken is written into the queue, and
// its first character then goes through the output register to the port.
// The output port carries one character per cycle while out_tready is high,
// so the single output port limits how fast bytes go through. in_tready
// drops only when the queue is full.
// When out_tready is low the output holds its character; the front keeps
// taking bytes until the queue fills.
// Reset (rst_n low, synchronous) empties the queue, drops out_tvalid and
// clears the pending bits, so the next byte starts a new message.
module base64_stream_encoder
  import b64enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tlast   // last_char
);

  b64_entry_t       new_entry;
  b64_entry_t       head;
  logic             take;
  logic             full;
  logic             empty;
  logic             pop;
  logic [CharW-1:0] out_char;

  assign in_tready = !full;
  assign take      = in_tvalid && !full;
  assign out_tdata = {1'b0, out_char};

  b64enc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .data_byte      (in_tdata),
    .end_of_message (in_tlast),
    .entry          (new_entry)
  );

  b64enc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_entry (new_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

endmodule

FILE: rtl/b64enc_front.sv
module b64enc_front
  import b64enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output b64_entry_t entry
);

  localparam logic [1:0] LO_0 = 2'd0;
  localparam logic [1:0] LO_2 = 2'd1;
  localparam logic [1:0] LO_4 = 2'd2;

  logic [3:0]  bits_r, bits_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  acc10;
  logic [11:0] acc12;
  logic [3:0]  rem_bits;
  logic [1:0]  rem_cnt;

  assign acc10 = {bits_r[1:0], data_byte};
  assign acc12 = {bits_r, data_byte};

  always_comb begin
    entry.chars    = '0;
    entry.last_idx = 2'd0;
    entry.last     = end_of_message;
    unique case (cnt_r)
      LO_0: begin
        entry.chars[0] = sym_char(data_byte[7:2]);
        rem_bits       = {2'b00, data_byte[1:0]};
        rem_cnt        = LO_2;
      end
      LO_2: begin
        entry.chars[0] = sym_char(acc10[9:4]);
        rem_bits       = acc10[3:0];
        rem_cnt        = LO_4;
      end
      default: begin
        entry.chars[0] = sym_char(acc12[11:6]);
        entry.chars[1] = sym_char(acc12[5:0]);
        entry.last_idx = 2'd1;
        rem_bits       = 4'd0;
        rem_cnt        = LO_0;
      end
    endcase

    bits_nxt = rem_bits;
    cnt_nxt  = rem_cnt;
    if (end_of_message) begin
      // tail symbol zero-extended on the right, then '=' padding
      if (rem_cnt == LO_2) begin
        entry.chars[1] = sym_char({rem_bits[1:0], 4'b0000});
        entry.chars[2] = PAD_CHAR;
        entry.chars[3] = PAD_CHAR;
        entry.last_idx = 2'd3;
      end else if (rem_cnt == LO_4) begin
        entry.chars[1] = sym_char({rem_bits, 2'b00});
        entry.chars[2] = PAD_CHAR;
        entry.last_idx = 2'd2;
      end
      bits_nxt = 4'd0;
      cnt_nxt  = LO_0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= 4'd0;
      cnt_r  <= LO_0;
    end else if (take) begin
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/b64enc_fifo.sv
module b64enc_fifo
  import b64enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  b64_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output b64_entry_t head,
  output logic       empty
);

  b64_entry_t          mem_r [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     cnt_r;

  assign full  = (cnt_r == CntW'(FifoDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/b64enc_back.sv
module b64enc_back
  import b64enc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  b64_entry_t       head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CharW-1:0] out_char,
  output logic             out_last
);

  logic [1:0]       idx_r;
  logic             valid_r;
  logic [CharW-1:0] char_r;
  logic             last_r;
  logic             emit;
  logic             final_char;

  assign emit       = !empty && (!valid_r || out_ready);
  assign final_char = (idx_r == head.last_idx);
  assign pop        = emit && final_char;

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (emit) begin
        valid_r <= 1'b1;
        idx_r   <= final_char ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r <= head.chars[idx_r];
      last_r <= head.last && final_char;
    end
  end

endmodule

FILE: verif/base64_stream_encoder_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the encoder, predicts the character stream from
// the accepted bytes and compares every accepted output character in order.
module base64_stream_encoder_checker
  import b64enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_message
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  input  logic       out_tlast,  // last_char
  output int         fail_count,
  output int         chars_waiting,
  output int         chars_seen
);

  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
  } enc_char_t;

  enc_char_t  char_q[$];
  logic [3:0] spare_bits;
  logic [2:0] spare_cnt;
  int         fails;
  int         seen;

  initial begin
    fail_count    = 0;
    chars_waiting = 0;
    chars_seen    = 0;
    fails         = 0;
    seen          = 0;
    spare_bits    = '0;
    spare_cnt     = '0;
  end

  // Alphabet is stored first character in the top byte.
  function automatic logic [CharW-1:0] b64_char(input logic [5:0] sym);
    return B64_ALPHABET[8*(63 - sym) +: CharW];
  endfunction

  // Appends the characters one byte produces to the expected stream.
  task automatic encode_byte(input logic [7:0] b, input logic eom);
    logic [11:0]      acc;
    logic [CharW-1:0] chs[4];
    int               n;
    int               pad;
    enc_char_t        e;
    n   = 0;
    pad = 0;
    case (spare_cnt)
      3'd0: begin
        chs[n++]   = b64_char(b[7:2]);
        spare_bits = {2'b00, b[1:0]};
        spare_cnt  = 3'd2;
      end
      3'd2: begin
        acc        = {2'b00, spare_bits[1:0], b};
        chs[n++]   = b64_char(acc[9:4]);
        spare_bits = acc[3:0];
        spare_cnt  = 3'd4;
      end
      default: begin
        acc        = {spare_bits, b};
        chs[n++]   = b64_char(acc[11:6]);
        chs[n++]   = b64_char(acc[5:0]);
        spare_bits = '0;
        spare_cnt  = 3'd0;
      end
    endcase
    if (eom) begin
      if (spare_cnt == 3'd2) begin
        chs[n++] = b64_char({spare_bits[1:0], 4'b0000});
        pad      = 2;
      end else if (spare_cnt == 3'd4) begin
        chs[n++] = b64_char({spare_bits, 2'b00});
        pad      = 1;
      end
      for (int i = 0; i < pad; i++) chs[n++] = PAD_CHAR;
      spare_bits = '0;
      spare_cnt  = 3'd0;
    end
    for (int i = 0; i < n; i++) begin
      e.ch   = chs[i];
      e.last = eom && (i == n - 1);
      char_q = {char_q, e};
    end
  endtask

  always @(posedge clk) begin
    enc_char_t exp_c;
    if (!rst_n) begin
      spare_bits = '0;
      spare_cnt  = '0;
      char_q.delete();
    end else begin
      // output first: a byte taken at this edge cannot show up yet
      if (out_tvalid && out_tready) begin
        seen++;
        if (char_q.size() == 0) begin
          $error("out_char: no character expected, got %0h", out_tdata[6:0]);
          fails++;
        end else begin
          exp_c = char_q.pop_front();
          if (out_tdata[6:0] !== exp_c.ch) begin
            $error("out_char: expected %0h, got %0h", exp_c.ch, out_tdata[6:0]);
            fails++;
          end
          if (out_tdata[7] !== 1'b0) begin
            $error("out_tdata[7]: expected 0, got %0b", out_tdata[7]);
            fails++;
          end
          if (out_tlast !== exp_c.last) begin
            $error("last_char: expected %0b, got %0b", exp_c.last, out_tlast);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) encode_byte(in_tdata, in_tlast);
    end
    fail_count    <= fails;
    chars_waiting <= char_q.size();
    chars_seen    <= seen;
  end

endmodule

FILE: verif/base64_stream_encoder_tb.sv
`timescale 1ns / 100ps

module base64_stream_encoder_tb;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  int fail_count;
  int chars_waiting;
  int chars_seen;
  int bytes_sent = 0;
  int msgs_sent  = 0;
  bit calm       = 1'b0;  // no idling on either side
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;

  base64_stream_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  base64_stream_encoder_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .chars_waiting (chars_waiting),
    .chars_seen    (chars_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500us;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off so the queue fills.
  initial begin
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eom;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (eom) msgs_sent++;
  endtask

  initial begin
    int       len;
    int       pick;
    bit [7:0] b;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one byte: tail plus two pads
    send_byte(8'h00, 1'b1);
    // two bytes: tail plus one pad
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // three bytes: no tail, symbol 62 everywhere
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    // symbol 63 everywhere
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // four zero bytes, ends with pending count zero then tail
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h7F, 1'b1);

    while (bytes_sent < 450) begin
      if (bytes_sent > 400) calm = 1'b1;
      if (bytes_sent > 100) hold_req = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      b = 8'h00;
        else if (pick == 1) b = 8'hFF;
        else                b = 8'($urandom_range(0, 255));
        send_byte(b, i == len - 1);
      end
    end
    in_tvalid <= 1'b0;

    while (chars_waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Encoded %0d bytes in %0d messages into %0d checked characters,",
             bytes_sent, msgs_sent, chars_seen);
    $display("with random stalls on both sides and one long output hold-off.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/b64enc_pkg.sv
rtl/b64enc_front.sv
rtl/b64enc_fifo.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder.sv
verif/base64_stream_encoder_checker.sv
verif/base64_stream_encoder_tb.sv
